>>> design/gbtle_pkg.sv
// shared types, codes and advance tables for the gb2312 text layout engine
// no dependencies; imported by gbtle_glyph and gb2312_text_layout_engine_top
package gbtle_pkg;

   localparam logic [7:0] LEAD_MIN   = 8'hA1;
   localparam logic [7:0] ASCII_LIM  = 8'h80;
   localparam logic [6:0] ROW_CELLS  = 7'd94;

   typedef enum logic [1:0] {
      KIND_ASCII = 2'd0,
      KIND_HANZI = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X  = 2'd0,
      CSR_ORIGIN_Y  = 2'd1,
      CSR_INK_COLOR = 2'd2,
      CSR_SIZE_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SIZE_16_8 = 2'd0,
      SIZE_14_7 = 2'd1,
      SIZE_12_8 = 2'd2,
      SIZE_ALT  = 2'd3
   } size_mode_type;

   typedef struct packed {
      logic        pending;
      logic [7:0]  lead;
      logic [15:0] cursor;
      logic [15:0] width;
   } line_state_type;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [7:0]  ink_color;
      logic [1:0]  size_mode;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] pos_x;
      logic [6:0]  ascii_code;
      logic [18:0] font_offset;
      logic [4:0]  glyph_size;
      logic [15:0] text_width;
   } glyph_type;

   function automatic logic [4:0] hanzi_adv(input logic [1:0] mode);
      logic [4:0] w;
      unique case (size_mode_type'(mode))
         SIZE_14_7: w = 5'd14;
         SIZE_12_8: w = 5'd12;
         SIZE_16_8,
         SIZE_ALT:  w = 5'd16;
      endcase
      return w;
   endfunction

   function automatic logic [4:0] ascii_adv(input logic [1:0] mode);
      logic [4:0] w;
      unique case (size_mode_type'(mode))
         SIZE_14_7: w = 5'd7;
         SIZE_16_8,
         SIZE_12_8,
         SIZE_ALT:  w = 5'd8;
      endcase
      return w;
   endfunction

endpackage

>>> design/gbtle_glyph.sv
// per-byte decode: lead/trail pairing, font offset, saturating cursor and width
// depends on gbtle_pkg
module gbtle_glyph import gbtle_pkg::*; (
   input  logic [7:0]     text_byte,
   input  line_state_type st,
   input  cfg_type        cfg,
   output line_state_type st_next,
   output logic           emit,
   output glyph_type      glyph
);

   logic        is_zero;
   logic        do_adv;
   logic [4:0]  adv_w;
   logic [15:0] cur_sum;
   logic [15:0] cur_adv;
   logic [16:0] wid_sum;
   logic [15:0] wid_adv;
   logic [6:0]  row_idx;
   logic [6:0]  col_idx;
   logic [13:0] cell_idx;
   logic [7:0]  lead_off;
   logic [7:0]  trail_off;

   assign is_zero   = (text_byte == 8'd0);
   assign lead_off  = st.lead - LEAD_MIN;
   assign trail_off = text_byte - LEAD_MIN;
   assign row_idx   = lead_off[6:0];
   assign col_idx   = trail_off[6:0];
   assign cell_idx  = 14'(row_idx * ROW_CELLS) + {7'd0, col_idx};

   // advance width for this byte
   always_comb begin
      do_adv = 1'b0;
      adv_w  = hanzi_adv(cfg.size_mode);
      if (st.pending) begin
         do_adv = 1'b1;
      end else if (!is_zero && text_byte < ASCII_LIM) begin
         do_adv = 1'b1;
         adv_w  = ascii_adv(cfg.size_mode);
      end
   end

   // saturating cursor and width
   assign cur_sum = st.cursor + {11'd0, adv_w};
   assign cur_adv = (!st.cursor[15] && cur_sum[15]) ? 16'h7FFF : cur_sum;
   assign wid_sum = {1'b0, st.width} + {12'd0, adv_w};
   assign wid_adv = wid_sum[16] ? 16'hFFFF : wid_sum[15:0];

   always_comb begin
      st_next           = st;
      emit              = 1'b0;
      glyph.kind        = KIND_ASCII;
      glyph.pos_x       = st.cursor;
      glyph.ascii_code  = 7'd0;
      glyph.font_offset = 19'd0;
      glyph.glyph_size  = adv_w;
      glyph.text_width  = do_adv ? wid_adv : st.width;
      if (do_adv) begin
         st_next.cursor = cur_adv;
         st_next.width  = wid_adv;
      end
      if (is_zero) begin
         emit              = 1'b1;
         glyph.kind        = KIND_END;
         glyph.pos_x       = do_adv ? cur_adv : st.cursor;
         glyph.glyph_size  = 5'd0;
         st_next.pending   = 1'b0;
         st_next.cursor    = cfg.origin_x;
         st_next.width     = 16'd0;
      end else if (st.pending) begin
         emit            = 1'b1;
         st_next.pending = 1'b0;
         if (text_byte < LEAD_MIN) begin
            glyph.kind = KIND_BAD;
         end else begin
            glyph.kind        = KIND_HANZI;
            glyph.font_offset = {cell_idx, 5'd0};
         end
      end else if (text_byte < ASCII_LIM) begin
         emit             = 1'b1;
         glyph.ascii_code = text_byte[6:0];
      end else if (text_byte >= LEAD_MIN) begin
         st_next.pending = 1'b1;
         st_next.lead    = text_byte;
      end
   end

endmodule

>>> design/gb2312_text_layout_engine_top.sv
// gb2312 text layout engine top level: channels, csr block and pipeline registers
// depends on gbtle_pkg and gbtle_glyph
//
// usage:
//  req_ channel carries one text byte per request (valid/stall); zero ends the text
//  rsp_ channel returns at most one glyph or end-of-text result per request
//  csr_ port writes origin_x, origin_y, ink_color, size_mode (index 0..3);
//   csr_ready is always high, writes belong between texts while the block is idle
//  writing origin_x restarts the line: cursor reloads, width clears, lead drops
//  a request accepted into the input register passes the glyph decode into the result
//   register, which drives rsp_; one byte per cycle while the receiver does not stall;
//   the glyph decode's short path (7x7 constant multiply, one 16 bit add) lands in the
//   result register
//  lead bytes and skipped bytes produce no result and never hold the pipeline
//  when the receiver stalls, the result register holds and the input register
//   keeps one request; req_stall rises only when both are occupied
//  reset clears the pipeline, the line state and all csr fields to zero
module gb2312_text_layout_engine_top import gbtle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [6:0]  rsp_ascii_code,
   output logic [18:0] rsp_font_offset,
   output logic [4:0]  rsp_glyph_size,
   output logic [7:0]  rsp_color_out,
   output logic [15:0] rsp_text_width,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   line_state_type st_ff, st_in, st_next;
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           rsp_valid_ff, rsp_valid_in;
   glyph_type      glyph_ff, glyph_in, glyph;
   logic [15:0]    pos_y_ff, pos_y_in;
   logic [7:0]     color_ff, color_in;
   logic           emit;
   logic           out_free;
   logic           s1_go;
   logic           csr_wr;

   gbtle_glyph u_glyph (
      .text_byte (in_byte_ff),
      .st        (st_ff),
      .cfg       (cfg_ff),
      .st_next   (st_next),
      .emit      (emit),
      .glyph     (glyph)
   );

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !s1_go;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:  cfg_in.origin_x  = csr_wdata;
            CSR_ORIGIN_Y:  cfg_in.origin_y  = csr_wdata;
            CSR_INK_COLOR: cfg_in.ink_color = csr_wdata[7:0];
            CSR_SIZE_MODE: cfg_in.size_mode = csr_wdata[1:0];
         endcase
      end
   end

   always_comb begin
      st_in = st_ff;
      if (csr_wr && csr_index_type'(csr_index) == CSR_ORIGIN_X) begin
         st_in.pending = 1'b0;
         st_in.cursor  = csr_wdata;
         st_in.width   = 16'd0;
      end else if (s1_go) begin
         st_in = st_next;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_text_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      glyph_in     = glyph_ff;
      pos_y_in     = pos_y_ff;
      color_in     = color_ff;
      if (s1_go && emit) begin
         rsp_valid_in = 1'b1;
         glyph_in     = glyph;
         pos_y_in     = cfg_ff.origin_y;
         color_in     = cfg_ff.ink_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         st_ff        <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         st_ff        <= st_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      glyph_ff   <= glyph_in;
      pos_y_ff   <= pos_y_in;
      color_ff   <= color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_kind   = glyph_ff.kind;
   assign rsp_pos_x       = glyph_ff.pos_x;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_ascii_code  = glyph_ff.ascii_code;
   assign rsp_font_offset = glyph_ff.font_offset;
   assign rsp_glyph_size  = glyph_ff.glyph_size;
   assign rsp_color_out   = color_ff;
   assign rsp_text_width  = glyph_ff.text_width;

endmodule

>>> sim/gb2312_text_layout_engine_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for gb2312_text_layout_engine_top: text byte requests and csr writes
// with random gaps and stalls, glyph commands predicted and checked in a scoreboard class
// depends on gbtle_pkg and gb2312_text_layout_engine_top
module gb2312_text_layout_engine_top_test;
   import gbtle_pkg::*;

   localparam int IDLE_LIMIT   = 400;
   localparam int RANDOM_BYTES = 780;
   localparam int LONG_TEXT    = 40;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [6:0]  ascii_code;
      logic [18:0] font_offset;
      logic [4:0]  glyph_size;
      logic [7:0]  color;
      logic [15:0] text_width;
   } glyph_cmd_type;

   class glyph_scoreboard;
      logic [15:0]   origin_x;
      logic [15:0]   origin_y;
      logic [7:0]    ink;
      size_mode_type mode;
      logic          lead_held;
      logic [7:0]    lead_byte;
      int            cursor;
      int            width;
      glyph_cmd_type glyph_queue[$];
      int            errors;

      function new();
         origin_x  = '0;
         origin_y  = '0;
         ink       = '0;
         mode      = SIZE_16_8;
         lead_byte = '0;
         errors    = 0;
         start_line();
      endfunction

      function void start_line();
         lead_held = 1'b0;
         cursor    = int'($signed(origin_x));
         width     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_ORIGIN_X: begin
               origin_x = data;
               start_line();
            end
            CSR_ORIGIN_Y:  origin_y = data;
            CSR_INK_COLOR: ink = data[7:0];
            CSR_SIZE_MODE: mode = size_mode_type'(data[1:0]);
            default: ;
         endcase
      endfunction

      function int hanzi_step();
         case (mode)
            SIZE_14_7: return 14;
            SIZE_12_8: return 12;
            default:   return 16;
         endcase
      endfunction

      function int latin_step();
         return (mode == SIZE_14_7) ? 7 : 8;
      endfunction

      function void advance(int w);
         cursor = cursor + w;
         if (cursor > 32767) cursor = 32767;
         width = width + w;
         if (width > 65535) width = 65535;
      endfunction

      function void push_glyph(kind_type k, int x, logic [6:0] code, int off, int w);
         glyph_cmd_type g;
         g.kind        = k;
         g.pos_x       = x[15:0];
         g.pos_y       = origin_y;
         g.ascii_code  = code;
         g.font_offset = off[18:0];
         g.glyph_size  = w[4:0];
         g.color       = ink;
         g.text_width  = width[15:0];
         glyph_queue.push_back(g);
      endfunction

      function void note_byte(logic [7:0] b);
         int x;
         int w;
         int off;
         if (b == 8'h00) begin
            if (lead_held) advance(hanzi_step());
            push_glyph(KIND_END, cursor, '0, 0, 0);
            start_line();
         end else if (lead_held) begin
            w = hanzi_step();
            x = cursor;
            lead_held = 1'b0;
            advance(w);
            if (b < LEAD_MIN) begin
               push_glyph(KIND_BAD, x, '0, 0, w);
            end else begin
               off = ((int'(lead_byte) - int'(LEAD_MIN)) * int'(ROW_CELLS)
                      + (int'(b) - int'(LEAD_MIN))) * 32;
               push_glyph(KIND_HANZI, x, '0, off, w);
            end
         end else if (b < ASCII_LIM) begin
            w = latin_step();
            x = cursor;
            advance(w);
            push_glyph(KIND_ASCII, x, b[6:0], 0, w);
         end else if (b >= LEAD_MIN) begin
            lead_held = 1'b1;
            lead_byte = b;
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_glyph(glyph_cmd_type got);
         glyph_cmd_type want;
         if (glyph_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d x %0d", got.kind, got.pos_x));
            return;
         end
         want = glyph_queue.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("item_kind %0d, want %0d", got.kind, want.kind));
         if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %h, want %h", got.pos_x, want.pos_x));
         if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %h, want %h", got.pos_y, want.pos_y));
         if (got.ascii_code !== want.ascii_code)
            report_mismatch($sformatf("ascii_code %h, want %h", got.ascii_code,
                                      want.ascii_code));
         if (got.font_offset !== want.font_offset)
            report_mismatch($sformatf("font_offset %0d, want %0d", got.font_offset,
                                      want.font_offset));
         if (got.glyph_size !== want.glyph_size)
            report_mismatch($sformatf("glyph_size %0d, want %0d", got.glyph_size,
                                      want.glyph_size));
         if (got.color !== want.color)
            report_mismatch($sformatf("color_out %h, want %h", got.color, want.color));
         if (got.text_width !== want.text_width)
            report_mismatch($sformatf("text_width %0d, want %0d", got.text_width,
                                      want.text_width));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [6:0]  rsp_ascii_code;
   logic [18:0] rsp_font_offset;
   logic [4:0]  rsp_glyph_size;
   logic [7:0]  rsp_color_out;
   logic [15:0] rsp_text_width;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   glyph_scoreboard sb;
   bit              quiet = 1'b0;
   int              hold_cycles = 0;
   int              bytes_sent = 0;
   logic [7:0]      opening_text[$] = '{8'h41, 8'h7F, 8'h01, 8'h80, 8'hA0, 8'hA1, 8'hA1,
                                        8'hFF, 8'hFF, 8'hB0, 8'hA0, 8'hC1, 8'h41, 8'hD7,
                                        8'h80, 8'hA1, 8'h00, 8'h00, 8'h9F, 8'hFE, 8'hFE,
                                        8'h55, 8'h00};

   gb2312_text_layout_engine_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_ascii_code  (rsp_ascii_code),
      .rsp_font_offset (rsp_font_offset),
      .rsp_glyph_size  (rsp_glyph_size),
      .rsp_color_out   (rsp_color_out),
      .rsp_text_width  (rsp_text_width),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin : monitor
      glyph_cmd_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall) sb.note_byte(req_text_byte);
         if (rsp_valid && !rsp_stall) begin
            got.kind        = kind_type'(rsp_item_kind);
            got.pos_x       = rsp_pos_x;
            got.pos_y       = rsp_pos_y;
            got.ascii_code  = rsp_ascii_code;
            got.font_offset = rsp_font_offset;
            got.glyph_size  = rsp_glyph_size;
            got.color       = rsp_color_out;
            got.text_width  = rsp_text_width;
            sb.check_glyph(got);
            hold_cycles = quiet ? 0 : $urandom_range(0, 13);
         end
      end
   end

   // receiver stall, drawn per accepted result
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [7:0] ink, input size_mode_type mode,
                            input logic [3:0] mask);
      if (mask[3]) csr_put(CSR_SIZE_MODE, {14'd0, mode});
      if (mask[1]) csr_put(CSR_ORIGIN_Y, oy);
      if (mask[0]) csr_put(CSR_ORIGIN_X, ox);
      if (mask[2]) csr_put(CSR_INK_COLOR, {8'd0, ink});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // idle point: request line low, all results back, input register drained (a held lead byte stays in the line state)
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.glyph_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'h7F00 + 16'($urandom_range(0, 255));
         4: return 16'h8000 + 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_glyph();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_byte(8'($urandom_range(1, 127)));
      end else if (pick < 85) begin
         send_byte(8'($urandom_range(161, 255)));
         send_byte(8'($urandom_range(161, 255)));
      end else if (pick < 90) begin
         send_byte(8'($urandom_range(128, 160)));
      end else begin
         send_byte(8'($urandom_range(161, 255)));
         send_byte(8'($urandom_range(1, 160)));
      end
   endtask

   task automatic send_text();
      int glyphs;
      glyphs = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 12);
      repeat (glyphs) send_glyph();
      if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(161, 255)));
      if ($urandom_range(0, 9) != 0) send_byte(8'h00);
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(16'd32720, 16'h8000, 8'hFF, SIZE_16_8, 4'hF);
      foreach (opening_text[i]) send_byte(opening_text[i]);

      while (bytes_sent < RANDOM_BYTES) begin
         settle();
         quiet = ($urandom_range(0, 4) == 0);
         configure(pick_coord(), pick_coord(),
                   ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom),
                   size_mode_type'($urandom_range(0, 3)), 4'($urandom_range(1, 15)));
         repeat ($urandom_range(1, 5)) send_text();
      end

      // one back to back line that runs the cursor into saturation
      settle();
      quiet = 1'b1;
      configure(16'h7FC0, 16'h1234, 8'h5A, SIZE_16_8, 4'hF);
      repeat (LONG_TEXT) send_byte(8'($urandom_range(1, 127)));
      send_byte(8'h00);
      settle();
      quiet = 1'b0;

      if (sb.glyph_queue.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.glyph_queue.size()));
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
design/gbtle_pkg.sv
design/gbtle_glyph.sv
design/gb2312_text_layout_engine_top.sv
sim/gb2312_text_layout_engine_top_test.sv
